// ----- rtl/ccf_pkg.sv -----
// shared types and constants of the cobs frame decoder with crc check
package ccf_pkg;

    localparam int DEF_MAX_PACKET = 36;
    localparam int PAY_MAX        = 32;
    localparam int MIN_PACKET     = 4;
    localparam int CFG_IDX_W      = 2;

    localparam logic [15:0] CRC_INIT = 16'hffff;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] CODE_FULL = 8'hff;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_COBS = 3'd2;
    localparam logic [2:0] ST_TYPE = 3'd3;
    localparam logic [2:0] ST_CRC  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TYPE_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_C = 2'd2;

    // frame summary handed from the receive side to the result side
    typedef struct packed {
        logic       cobs_err;
        logic       too_short;
        logic       len_bad;
        logic       crc_bad;
        logic [7:0] msg_type;
        logic [7:0] pay_len;
    } t_rx_status;

endpackage

// ----- rtl/ccf_ifs.sv -----
// valid/ready channel interfaces for frame bytes, results and configuration
interface ccf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface ccf_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] msg_type;
    logic [5:0] pay_len;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic       last;

    modport source (output valid, output status, output msg_type, output pay_len,
                    output payload_byte, output byte_index, output last, input ready);
    modport sink (input valid, input status, input msg_type, input pay_len,
                  input payload_byte, input byte_index, input last, output ready);
endinterface

interface ccf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ccf_cobs_rx.sv -----
// cobs unstuffing, running crc and packet memory with a registered read port
module ccf_cobs_rx #(
    parameter int MAX_PACKET = ccf_pkg::DEF_MAX_PACKET,
    parameter int AW         = $clog2(MAX_PACKET)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_clear,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [7:0]          o_rd_data,
    output ccf_pkg::t_rx_status o_status
);
    import ccf_pkg::*;

    localparam int CW = $clog2(MAX_PACKET + 1);

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    logic [7:0]    r_mem [MAX_PACKET];
    logic [7:0]    r_rd_data;

    logic [CW-1:0] r_count;
    logic [7:0]    r_grp;
    logic          r_full;
    logic          r_owed;
    logic          r_failed;
    logic [15:0]   r_crc;
    logic [7:0]    r_prev1;
    logic [7:0]    r_prev2;
    logic [7:0]    r_type;
    logic [7:0]    r_len;

    logic [7:0]    n_grp;
    logic          n_full;
    logic          n_owed;
    logic          n_failed;
    logic          w_store_req;
    logic [7:0]    w_store_val;
    logic          w_room;
    logic          w_store;

    assign w_room  = (r_count < CW'(MAX_PACKET));
    assign w_store = w_store_req && w_room;

    always_comb begin
        n_grp       = r_grp;
        n_full      = r_full;
        n_owed      = r_owed;
        n_failed    = r_failed;
        w_store_req = 1'b0;
        w_store_val = i_byte;
        if (i_take && !r_failed) begin
            if (r_grp == 8'd0) begin
                if (i_byte == 8'd0) begin
                    n_failed = 1'b1;
                end else if (r_owed && !w_room) begin
                    // trailing zero of the previous group overflows the packet
                    w_store_req = 1'b1;
                    w_store_val = 8'd0;
                    n_failed    = 1'b1;
                end else begin
                    if (r_owed) begin
                        w_store_req = 1'b1;
                        w_store_val = 8'd0;
                    end
                    n_grp  = i_byte - 8'd1;
                    n_full = (i_byte == CODE_FULL);
                    n_owed = (i_byte == 8'd1);
                end
            end else begin
                w_store_req = 1'b1;
                if (!w_room) begin
                    n_failed = 1'b1;
                end else begin
                    n_grp = r_grp - 8'd1;
                    if (r_grp == 8'd1) begin
                        n_owed = !r_full;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count  <= '0;
            r_grp    <= 8'd0;
            r_full   <= 1'b0;
            r_owed   <= 1'b0;
            r_failed <= 1'b0;
            r_crc    <= CRC_INIT;
        end else begin
            r_grp    <= n_grp;
            r_full   <= n_full;
            r_owed   <= n_owed;
            r_failed <= n_failed;
            if (w_store) begin
                r_count <= r_count + CW'(1);
                // crc trails the newest two bytes, which may be the received crc
                if (r_count >= CW'(2)) begin
                    r_crc <= crc16_feed(r_crc, r_prev2);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[AW-1:0]] <= w_store_val;
            r_prev1 <= w_store_val;
            r_prev2 <= r_prev1;
            if (r_count == CW'(0)) begin
                r_type <= w_store_val;
            end
            if (r_count == CW'(1)) begin
                r_len <= w_store_val;
            end
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data          = r_rd_data;
    assign o_status.cobs_err  = r_failed || (r_grp != 8'd0);
    assign o_status.too_short = (r_count < CW'(MIN_PACKET));
    assign o_status.len_bad   = (r_len > 8'(PAY_MAX))
                             || (9'(r_count) != ({1'b0, r_len} + 9'(MIN_PACKET)));
    assign o_status.crc_bad   = ({r_prev1, r_prev2} != r_crc);
    assign o_status.msg_type  = r_type;
    assign o_status.pay_len   = r_len;

endmodule

// ----- rtl/cobs_crc_frame_decoder.sv -----
// top level of the cobs frame decoder: frame checks, payload readout, config registers
//
//   channel   dir  handshake     carries
//   i_frame   in   valid/ready   frame_byte, frame_end
//   o_result  out  valid/ready   status, msg_type, pay_len, payload_byte,
//                                byte_index, last
//   i_cfg     in   valid/ready   index, data (known type codes)
//
// frame bytes transfer one per cycle while receiving; the unstuffer stores at most
// one decoded byte per cycle into the packet memory.
// after the last byte the frame is judged; an error or empty payload gives its single
// result in the judge state, otherwise each payload byte takes a memory read, then an
// output register load, and input is held off until the last result has been loaded.
// reset is synchronous and clears control state; the packet memory is not cleared.
// the output register holds a result under stall while the next frame is received.
module cobs_crc_frame_decoder #(
    parameter int MAX_PACKET = ccf_pkg::DEF_MAX_PACKET
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ccf_frame_if.sink    i_frame,
    ccf_result_if.source o_result,
    ccf_cfg_if.sink      i_cfg
);
    import ccf_pkg::*;

    localparam int AW = $clog2(MAX_PACKET);

    localparam logic [1:0] S_RX    = 2'd0;
    localparam logic [1:0] S_JUDGE = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_WAIT  = 2'd3;

    logic [1:0]    r_state;
    logic [AW-1:0] r_idx;
    logic [7:0]    r_type_a;
    logic [7:0]    r_type_b;
    logic [7:0]    r_type_c;

    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [7:0]    r_out_type;
    logic [5:0]    r_out_len;
    logic [7:0]    r_out_byte;
    logic [4:0]    r_out_idx;
    logic          r_out_last;

    t_rx_status    w_rx;
    logic [7:0]    w_rd_data;
    logic          w_accept;
    logic          w_take;
    logic          w_clear;
    logic          w_rd_en;
    logic          w_out_free;
    logic          w_out_load;
    logic          w_type_known;
    logic [2:0]    w_status;
    logic          w_final;

    assign i_frame.ready = (r_state == S_RX);
    assign w_accept      = i_frame.valid && i_frame.ready;
    // a zero closing the frame is a delimiter, not data
    assign w_take        = w_accept && !(i_frame.frame_end && (i_frame.frame_byte == 8'd0));
    assign w_out_free    = !r_out_valid || o_result.ready;
    assign w_clear       = (r_state == S_JUDGE) && w_out_free;
    assign w_rd_en       = (r_state == S_READ);
    assign w_final       = ((8'(r_idx) + 8'd1) == w_rx.pay_len);
    assign w_out_load    = w_out_free && ((r_state == S_WAIT) || ((r_state == S_JUDGE)
                           && ((w_status != ST_OK) || (w_rx.pay_len == 8'd0))));

    ccf_cobs_rx #(
        .MAX_PACKET (MAX_PACKET),
        .AW         (AW)
    ) u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_byte    (i_frame.frame_byte),
        .i_clear   (w_clear),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx + AW'(2)),
        .o_rd_data (w_rd_data),
        .o_status  (w_rx)
    );

    assign w_type_known = (w_rx.msg_type == r_type_a) || (w_rx.msg_type == r_type_b)
                       || (w_rx.msg_type == r_type_c);

    always_comb begin
        if (w_rx.cobs_err) begin
            w_status = ST_COBS;
        end else if (w_rx.too_short) begin
            w_status = ST_LEN;
        end else if (!w_type_known) begin
            w_status = ST_TYPE;
        end else if (w_rx.len_bad) begin
            w_status = ST_LEN;
        end else if (w_rx.crc_bad) begin
            w_status = ST_CRC;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RX;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_RX: begin
                    if (w_accept && i_frame.frame_end) begin
                        r_state <= S_JUDGE;
                    end
                end
                S_JUDGE: begin
                    if (w_out_free) begin
                        r_idx <= '0;
                        if ((w_status != ST_OK) || (w_rx.pay_len == 8'd0)) begin
                            r_state <= S_RX;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= w_final ? S_RX : S_READ;
                    end
                end
                default: begin
                    r_state <= S_RX;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_JUDGE) && w_out_free) begin
            r_out_status <= w_status;
            r_out_type   <= (w_status == ST_OK) ? w_rx.msg_type : 8'd0;
            r_out_len    <= 6'd0;
            r_out_byte   <= 8'd0;
            r_out_idx    <= 5'd0;
            r_out_last   <= 1'b1;
        end else if ((r_state == S_WAIT) && w_out_free) begin
            r_out_status <= ST_OK;
            r_out_type   <= w_rx.msg_type;
            r_out_len    <= w_rx.pay_len[5:0];
            r_out_byte   <= w_rd_data;
            r_out_idx    <= 5'(r_idx);
            r_out_last   <= w_final;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out_status;
    assign o_result.msg_type     = r_out_type;
    assign o_result.pay_len      = r_out_len;
    assign o_result.payload_byte = r_out_byte;
    assign o_result.byte_index   = r_out_idx;
    assign o_result.last         = r_out_last;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_a <= 8'd1;
            r_type_b <= 8'd2;
            r_type_c <= 8'd3;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_TYPE_A: r_type_a <= i_cfg.data;
                REG_TYPE_B: r_type_b <= i_cfg.data;
                REG_TYPE_C: r_type_c <= i_cfg.data;
                default: ;
            endcase
        end
    end

    a_end_to_judge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_frame.frame_end) |=> (r_state == S_JUDGE))
        else $error("frame end transfer did not start judging");

    a_wait_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> ($past(r_state) == S_READ || $past(r_state) == S_WAIT))
        else $error("payload load without a memory read");

    a_error_result_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |->
            (r_out_last && (r_out_byte == 8'd0) && (r_out_idx == 5'd0) && (r_out_len == 6'd0)))
        else $error("error result carries payload fields");

endmodule
